/* sv/cop_pkg.sv */
// package for the circle octant point generator
// holds the default coordinate width, pass kind codes and the pass state type
// no dependencies
`default_nettype none

package cop_pkg;

   localparam int COORD_BITS_DEF = 12;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_FWD   = 2'd1;
   localparam logic [1:0] KIND_REV   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_FWD  = 2'd1,
      ST_REV  = 2'd2
   } pass_state_type;

endpackage

`default_nettype wire

/* sv/cop_if.sv */
// channel interfaces of the circle octant point generator
// step request, point result and radius write channels, valid/ready each
// widths follow the coordinate width; no package dependency
`default_nettype none

interface cop_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source(output valid, output restart, input ready);
   modport sink(input valid, input restart, output ready);
endinterface

interface cop_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic                         valid_res;
   logic [COORD_BITS-1:0]        point_x;
   logic signed [COORD_BITS+1:0] point_y;
   logic [1:0]                   pass_kind;
   logic                         last_point;

   modport source(output valid, output valid_res, output point_x, output point_y,
                  output pass_kind, output last_point, input ready);
   modport sink(input valid, input valid_res, input point_x, input point_y,
                input pass_kind, input last_point, output ready);
endinterface

interface cop_csr_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/circle_octant_point_generator.sv */
// circle octant point generator, midpoint rule, one result beat per request beat, holding at most one point
// a request beat is registered into stage one, and its result is then registered into the output stage for rsp_bus
// throughput: one request beat per cycle while rsp_bus does not stall, the step update being combinational
// reset: synchronous, clears radius, pass state and the valid flags of both pipeline stages
// uses cop_pkg and the interfaces in cop_if.sv
`default_nettype none

module circle_octant_point_generator #(
   parameter int COORD_BITS = cop_pkg::COORD_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   cop_req_if.sink     req_bus,
   cop_rsp_if.source   rsp_bus,
   cop_csr_if.sink     csr_bus
);

   localparam int X_BITS  = COORD_BITS + 1;
   localparam int Y_BITS  = COORD_BITS + 2;
   localparam int E_BITS  = COORD_BITS + 4;
   localparam int R2_BITS = 2 * COORD_BITS;
   localparam int SQ_BITS = 2 * COORD_BITS + 2;

   // radius register and its square
   logic [COORD_BITS-1:0] radius_ff;
   logic [R2_BITS-1:0]    r_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         r_sq_ff   <= '0;
      end else if (csr_bus.valid) begin
         radius_ff <= csr_bus.data;
         r_sq_ff   <= R2_BITS'(csr_bus.data) * R2_BITS'(csr_bus.data);
      end
   end

   assign csr_bus.ready = 1'b1;

   // pipeline control
   logic s1_valid_ff;
   logic s1_restart_ff;
   logic out_valid_ff;
   logic s1_move;

   assign s1_move       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_restart_ff <= req_bus.restart;
      end
   end

   // step state
   cop_pkg::pass_state_type  state_ff, state_in;
   logic [X_BITS-1:0]        x_ff, x_in;
   logic signed [Y_BITS-1:0] y_ff, y_in;
   logic signed [E_BITS-1:0] err_ff, err_in;
   logic signed [E_BITS-1:0] odd_ff, odd_in;
   logic [SQ_BITS-1:0]       t_ff, t_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cop_pkg::ST_IDLE;
         x_ff     <= '0;
         y_ff     <= '0;
         err_ff   <= '0;
         odd_ff   <= '1;
         t_ff     <= '0;
      end else if (s1_move) begin
         state_ff <= state_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         err_ff   <= err_in;
         odd_ff   <= odd_in;
         t_ff     <= t_in;
      end
   end

   // result payload
   logic                     res_valid_in, res_valid_ff;
   logic [COORD_BITS-1:0]    res_x_in, res_x_ff;
   logic signed [Y_BITS-1:0] res_y_in, res_y_ff;
   logic [1:0]               res_kind_in, res_kind_ff;
   logic                     res_last_in, res_last_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         res_valid_ff <= res_valid_in;
         res_x_ff     <= res_x_in;
         res_y_ff     <= res_y_in;
         res_kind_ff  <= res_kind_in;
         res_last_ff  <= res_last_in;
      end
   end

   // step logic
   logic                     fwd_ok;
   logic                     do_rev;
   logic signed [E_BITS-1:0] y_ext;
   logic signed [E_BITS-1:0] odd_up;
   logic signed [E_BITS-1:0] fwd_e1;
   logic signed [Y_BITS-1:0] fwd_y;
   logic signed [E_BITS-1:0] rev_e1;

   always_comb begin
      y_ext  = E_BITS'(y_ff);
      fwd_ok = t_ff < SQ_BITS'(r_sq_ff);
      odd_up = odd_ff + E_BITS'(2);
      fwd_e1 = err_ff + odd_up;
      fwd_y  = (fwd_e1 >= 0) ? y_ff - Y_BITS'(1) : y_ff;
      rev_e1 = err_ff + (y_ext <<< 1) - odd_ff;
      do_rev = (state_ff == cop_pkg::ST_REV) ||
               ((state_ff == cop_pkg::ST_FWD) && !fwd_ok);

      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      odd_in       = odd_ff;
      t_in         = t_ff;
      res_valid_in = 1'b0;
      res_x_in     = '0;
      res_y_in     = '0;
      res_kind_in  = cop_pkg::KIND_START;
      res_last_in  = 1'b0;

      if (s1_restart_ff) begin
         x_in         = '0;
         y_in         = Y_BITS'(radius_ff);
         err_in       = -E_BITS'(radius_ff);
         odd_in       = '1;
         t_in         = SQ_BITS'(2);
         state_in     = (radius_ff <= COORD_BITS'(1)) ? cop_pkg::ST_IDLE : cop_pkg::ST_FWD;
         res_valid_in = 1'b1;
         res_y_in     = Y_BITS'(radius_ff);
         res_kind_in  = cop_pkg::KIND_START;
         res_last_in  = (radius_ff <= COORD_BITS'(1));
      end else if ((state_ff == cop_pkg::ST_FWD) && fwd_ok) begin
         odd_in       = odd_up;
         y_in         = fwd_y;
         err_in       = (fwd_e1 >= 0) ? fwd_e1 - (E_BITS'(fwd_y) <<< 1) : fwd_e1;
         x_in         = x_ff + X_BITS'(1);
         t_in         = t_ff + (SQ_BITS'(x_ff) << 2) + SQ_BITS'(6);
         res_valid_in = 1'b1;
         res_x_in     = COORD_BITS'(x_ff + X_BITS'(1));
         res_y_in     = fwd_y;
         res_kind_in  = cop_pkg::KIND_FWD;
      end else if (do_rev) begin
         if (x_ff == '0) begin
            state_in = cop_pkg::ST_IDLE;
         end else begin
            err_in       = (rev_e1 >= 0) ? rev_e1 - (y_ext <<< 1) : rev_e1;
            y_in         = (rev_e1 >= 0) ? y_ff : y_ff + Y_BITS'(1);
            odd_in       = odd_ff - E_BITS'(2);
            x_in         = x_ff - X_BITS'(1);
            state_in     = (x_ff == X_BITS'(1)) ? cop_pkg::ST_IDLE : cop_pkg::ST_REV;
            res_valid_in = 1'b1;
            res_x_in     = x_ff[COORD_BITS-1:0];
            res_y_in     = y_ff;
            res_kind_in  = cop_pkg::KIND_REV;
            res_last_in  = (x_ff == X_BITS'(1));
         end
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.valid_res  = res_valid_ff;
   assign rsp_bus.point_x    = res_x_ff;
   assign rsp_bus.point_y    = res_y_ff;
   assign rsp_bus.pass_kind  = res_kind_ff;
   assign rsp_bus.last_point = res_last_ff;

   // checks
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !out_valid_ff && (state_ff == cop_pkg::ST_IDLE))
      else $error("pipeline not cleared by reset");

   a_last_is_point: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_last_ff |-> res_valid_ff)
      else $error("last point flag without a point");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !res_valid_ff |->
         (res_x_ff == '0) && (res_y_ff == '0) && (res_kind_ff == cop_pkg::KIND_START))
      else $error("exhausted beat carries nonzero payload");

   a_rev_nonzero_x: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cop_pkg::ST_REV) |-> (x_ff != '0))
      else $error("reverse pass holding x at zero");

   a_start_at_axis: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_valid_ff && (res_kind_ff == cop_pkg::KIND_START) |->
         (res_x_ff == '0))
      else $error("start point off the y axis");

endmodule

`default_nettype wire

/* tb/circle_octant_point_generator_tb.sv */
// testbench for circle_octant_point_generator: walks circle octants over many radius
// settings and checks every point beat against an in-bench midpoint predictor
// depends on cop_pkg, the interfaces in cop_if.sv and the generator rtl

module circle_octant_point_generator_tb;

   localparam int CB            = cop_pkg::COORD_BITS_DEF;
   localparam int PERIOD        = 10;
   localparam int LIMIT_CYCLES  = 1_500_000;
   localparam int RANDOM_POINTS = 1500;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_RADIUS    = (1 << CB) - 1;

   typedef struct {
      logic                 valid_res;
      logic [CB-1:0]        point_x;
      logic signed [CB+1:0] point_y;
      logic [1:0]           pass_kind;
      logic                 last_point;
   } octant_point_type;

   logic clock;
   logic reset;

   cop_req_if                    req_bus();
   cop_rsp_if #(.COORD_BITS(CB)) rsp_bus();
   cop_csr_if #(.COORD_BITS(CB)) csr_bus();

   circle_octant_point_generator #(.COORD_BITS(CB)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   octant_point_type        pending_points[$];
   int                      radius_q;
   int                      x_q;
   int                      y_q;
   int                      err_q;
   int                      odd_q;
   cop_pkg::pass_state_type pass_q;
   int                      fail_count       = 0;
   int                      points_given     = 0;
   bit                      sender_idle_on   = 1'b1;
   bit                      receiver_idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(PERIOD * LIMIT_CYCLES);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic octant_point_type make_point(input bit valid, input int x, input int y,
                                                   input logic [1:0] kind, input bit last);
      octant_point_type pt;
      pt.valid_res  = valid;
      pt.point_x    = x[CB-1:0];
      pt.point_y    = y[CB+1:0];
      pt.pass_kind  = kind;
      pt.last_point = last;
      return pt;
   endfunction

   // midpoint octant step; updates the predicted state and returns the point
   function automatic octant_point_type next_octant_point(input bit restart_bit);
      int nx;
      int px;
      int py;
      bit last;
      if (restart_bit) begin
         last   = (radius_q * radius_q) <= 2;
         x_q    = 0;
         y_q    = radius_q;
         err_q  = -radius_q;
         odd_q  = -1;
         pass_q = last ? cop_pkg::ST_IDLE : cop_pkg::ST_FWD;
         return make_point(1'b1, 0, y_q, cop_pkg::KIND_START, last);
      end
      if (pass_q == cop_pkg::ST_FWD) begin
         nx = x_q + 1;
         if (2 * nx * nx < radius_q * radius_q) begin
            odd_q += 2;
            err_q += odd_q;
            if (err_q >= 0) begin
               y_q   -= 1;
               err_q -= 2 * y_q;
            end
            x_q = nx;
            return make_point(1'b1, x_q, y_q, cop_pkg::KIND_FWD, 1'b0);
         end
         pass_q = cop_pkg::ST_REV;
      end
      if (pass_q == cop_pkg::ST_REV) begin
         if (x_q <= 0) begin
            pass_q = cop_pkg::ST_IDLE;
            return make_point(1'b0, 0, 0, cop_pkg::KIND_START, 1'b0);
         end
         px    = x_q;
         py    = y_q;
         err_q += 2 * y_q;
         err_q -= odd_q;
         if (err_q >= 0)
            err_q -= 2 * y_q;
         else
            y_q += 1;
         odd_q -= 2;
         x_q   -= 1;
         if (x_q == 0)
            pass_q = cop_pkg::ST_IDLE;
         return make_point(1'b1, px, py, cop_pkg::KIND_REV, px == 1);
      end
      return make_point(1'b0, 0, 0, cop_pkg::KIND_START, 1'b0);
   endfunction

   task automatic send_step(input bit restart_bit);
      int               gap;
      octant_point_type pt;
      gap = sender_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart_bit;
      do @(posedge clock); while (!req_bus.ready);
      pt = next_octant_point(restart_bit);
      if (pt.valid_res)
         points_given++;
      pending_points.push_back(pt);
   endtask

   task automatic wait_drained;
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(input int value);
      logic [CB-1:0] data;
      data = value[CB-1:0];
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      radius_q = int'(data);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic finish_octant;
      while (pass_q != cop_pkg::ST_IDLE) send_step(1'b0);
   endtask

   // result side: random stall per beat, then compare with the oldest prediction
   initial begin : point_checker
      int               stall;
      octant_point_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = receiver_idle_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (pending_points.size() == 0) begin
            $error("point beat with no request outstanding");
            fail_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_bus.valid_res !== want.valid_res) begin
               $error("valid_res: expected %0d, got %0d", want.valid_res, rsp_bus.valid_res);
               fail_count++;
            end
            if (rsp_bus.point_x !== want.point_x) begin
               $error("point_x: expected %0d, got %0d", want.point_x, rsp_bus.point_x);
               fail_count++;
            end
            if (rsp_bus.point_y !== want.point_y) begin
               $error("point_y: expected %0d, got %0d", want.point_y, rsp_bus.point_y);
               fail_count++;
            end
            if (rsp_bus.pass_kind !== want.pass_kind) begin
               $error("pass_kind: expected %0d, got %0d", want.pass_kind, rsp_bus.pass_kind);
               fail_count++;
            end
            if (rsp_bus.last_point !== want.last_point) begin
               $error("last_point: expected %0d, got %0d", want.last_point,
                      rsp_bus.last_point);
               fail_count++;
            end
         end
      end
   end

   // no point before the first restart, then a restart at the reset radius of zero
   task automatic test_idle_after_reset;
      send_step(1'b0);
      send_step(1'b0);
      send_step(1'b1);
      send_step(1'b0);
   endtask

   // radius one ends at the start point, radius two has one step each way
   task automatic test_tiny_radius;
      for (int r = 1; r <= 2; r++) begin
         write_radius(r);
         send_step(1'b1);
         finish_octant();
         send_step(1'b0);
      end
   endtask

   // full-scale start point, then a shrink cuts the forward pass short
   task automatic test_max_radius_shrink;
      write_radius(MAX_RADIUS);
      send_step(1'b1);
      repeat (4) send_step(1'b0);
      write_radius(2);
      finish_octant();
      send_step(1'b0);
   endtask

   // shrink right after restart sends the reverse pass in at x of zero
   task automatic test_shrink_at_start;
      write_radius(50);
      send_step(1'b1);
      write_radius(1);
      send_step(1'b0);
      send_step(1'b0);
   endtask

   task automatic test_random_sequences;
      int target;
      int sel;
      int steps;
      int k;
      target = points_given + RANDOM_POINTS;
      while (points_given < target) begin
         sender_idle_on   = $urandom_range(0, 3) != 0;
         receiver_idle_on = $urandom_range(0, 3) != 0;
         sel = $urandom_range(0, 9);
         if (sel == 0)
            write_radius($urandom_range(0, 2));
         else if (sel == 1)
            write_radius($urandom_range(0, MAX_RADIUS));
         else if (sel < 9)
            write_radius($urandom_range(3, 60));
         // large radii only get a short stretch of the octant
         steps = (radius_q > 60) ? $urandom_range(1, 40) : 200;
         send_step(1'b1);
         k = 0;
         while (pass_q != cop_pkg::ST_IDLE && k < steps) begin
            case ($urandom_range(0, 59))
               0: send_step(1'b1);
               1: write_radius($urandom_range(0, radius_q));
               2: begin
                  wait_drained();
                  send_step(1'b0);
               end
               default: send_step(1'b0);
            endcase
            k++;
         end
         repeat ($urandom_range(0, 3)) send_step($urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      radius_q        = 0;
      x_q             = 0;
      y_q             = 0;
      err_q           = 0;
      odd_q           = -1;
      pass_q          = cop_pkg::ST_IDLE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_after_reset();
      test_tiny_radius();
      test_max_radius_shrink();
      test_shrink_at_start();
      test_random_sequences();

      wait_drained();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
sv/cop_pkg.sv
sv/cop_if.sv
sv/circle_octant_point_generator.sv
tb/circle_octant_point_generator_tb.sv
